/* hw/rtl/fpsvm_pkg.sv */
// ----------------------------------------------------------------------------
// fpsvm_pkg
// Shared types, codes and Q32.32 helpers for the fixed-point stack machine.
// ----------------------------------------------------------------------------
package fpsvm_pkg;

    localparam int CMD_W      = 4;
    localparam int VAL_W      = 64;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VAR_SLOTS   = 64;
    localparam int DEF_PROGRAM_MAX = 256;

    localparam logic [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_STORE = 4'd2,
        CMD_ADD   = 4'd3,
        CMD_SUB   = 4'd4,
        CMD_MUL   = 4'd5,
        CMD_DIV   = 4'd6,
        CMD_NEG   = 4'd7,
        CMD_HALT  = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_UNDEF    = 3'd4,
        ST_LONG     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    // Magnitude of a two's complement value (the most negative value maps to 2^63).
    function automatic logic [VAL_W-1:0] q_mag(input logic [VAL_W-1:0] a);
        q_mag = a[VAL_W-1] ? (~a + 1'b1) : a;
    endfunction

    // Apply a sign to an unsigned magnitude hi:lo, saturating to the Q32.32 range.
    function automatic logic [VAL_W-1:0] q_signed(input logic [VAL_W-1:0] hi,
                                                  input logic [VAL_W-1:0] lo,
                                                  input logic             neg);
        logic [VAL_W-1:0] lim;
        lim = neg ? Q_MIN : Q_MAX;
        if (hi != '0 || lo > lim)
            q_signed = lim;
        else
            q_signed = neg ? (~lo + 1'b1) : lo;
    endfunction

endpackage

/* hw/rtl/fixed_point_stack_vm.sv */
// ----------------------------------------------------------------------------
// fixed_point_stack_vm
// Stack-machine executor on signed Q32.32 with a memory-held operand stack.
// ----------------------------------------------------------------------------
// An instruction is accepted in S_IDLE and executed in S_EXEC, after the
// registered read of the stack and variable memories; no new one is accepted
// until it is done. A multiply goes on in the shared 32x32 multiplier, a divide
// in the bit-serial divider. An instruction marked last then forms the result
// in S_FIN, which waits for the output register to drain.
// Reset clears the control state, stack depth, slot marks and output valid.
// ----------------------------------------------------------------------------
module fixed_point_stack_vm #(
    parameter int STACK_DEPTH = fpsvm_pkg::DEF_STACK_DEPTH,
    parameter int VAR_SLOTS   = fpsvm_pkg::DEF_VAR_SLOTS,
    parameter int PROGRAM_MAX = fpsvm_pkg::DEF_PROGRAM_MAX
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: cmd[3:0], immediate[67:4], slot[73:68], zero fill above.
    input  logic [fpsvm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status[2:0], value[66:3], zero fill above.
    output logic [fpsvm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fpsvm_pkg::*;

    // Only slots that the 6-bit slot field can name get storage.
    localparam int SLOT_LEVELS = 1 << SLOT_W;
    localparam int SLOTS_USED  = (VAR_SLOTS < SLOT_LEVELS) ? VAR_SLOTS : SLOT_LEVELS;
    localparam int SA_W        = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
    localparam int VAR_ENTRIES = 1 << SA_W;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int IC_W        = $clog2(PROGRAM_MAX + 1);

    // Control and item registers.
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg;
    logic [VAL_W-1:0]       imm_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   last_reg;

    // Program state. The top of stack lives in a register; the entries below
    // it live in the stack memory.
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VAL_W-1:0]       tos_reg, tos_next;
    status_t                status_reg, status_next;
    logic                   halted_reg, halted_next;
    logic [IC_W-1:0]        icnt_reg, icnt_next;

    // Each slot has two banks in the variable memory. The committed bank is
    // marked per slot; stores go to the other bank, and a good program end
    // flips the mark of every written slot, which commits without a copy.
    logic [VAR_ENTRIES-1:0] written_reg, written_next;
    logic [VAR_ENTRIES-1:0] defined_reg, defined_next;
    logic [VAR_ENTRIES-1:0] cbank_reg, cbank_next;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [VAL_W-1:0]       out_value_reg, out_value_next;

    // Memories.
    logic [VAL_W-1:0]       stk_mem [STACK_DEPTH];
    logic [VAL_W-1:0]       var_mem [2*VAR_ENTRIES];
    logic [VAL_W-1:0]       stk_rd_reg;
    logic [VAL_W-1:0]       var_rd_reg;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr;
    logic [IDX_W-1:0]       stk_raddr;
    logic                   var_we;
    logic [SA_W:0]          var_waddr;
    logic [SA_W:0]          var_raddr;

    // Item fields as they arrive.
    logic                   accept;
    cmd_t                   in_cmd;
    logic [VAL_W-1:0]       in_imm;
    logic [SLOT_W-1:0]      in_slot;
    logic [SA_W-1:0]        in_sa;
    logic [SA_W-1:0]        sa;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;

    // Arithmetic units.
    logic                   mul_start, mul_done, div_start, div_done;
    logic [VAL_W-1:0]       mul_res, div_res;

    // Execute decisions and result formation.
    logic                   out_free;
    status_t                fin_status;
    logic                   fin_ok;
    logic [VAL_W-1:0]       sum, diff;

    assign accept   = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_imm   = s_tdata[CMD_W+VAL_W-1:CMD_W];
    assign in_slot  = s_tdata[CMD_W+VAL_W+SLOT_W-1:CMD_W+VAL_W];
    assign in_sa    = in_slot[SA_W-1:0];
    assign sa       = slot_reg[SA_W-1:0];
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign out_free = !out_valid_reg || m_tready;

    // The reads are issued on the accept edge, so the data is ready in S_EXEC.
    // Writes happen only in S_EXEC, never next to a read that needs them.
    assign stk_raddr = cnt_m2[IDX_W-1:0];
    assign var_raddr = {written_reg[in_sa] ^ cbank_reg[in_sa], in_sa};

    fpsvm_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (stk_rd_reg),
        .b      (tos_reg),
        .done   (mul_done),
        .result (mul_res)
    );

    fpsvm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .a      (stk_rd_reg),
        .b      (tos_reg),
        .done   (div_done),
        .result (div_res)
    );

    // Saturating add and subtract of the two top entries.
    always_comb
    begin
        sum  = stk_rd_reg + tos_reg;
        diff = stk_rd_reg - tos_reg;
        if (stk_rd_reg[VAL_W-1] == tos_reg[VAL_W-1] && sum[VAL_W-1] != stk_rd_reg[VAL_W-1])
            sum = stk_rd_reg[VAL_W-1] ? Q_MIN : Q_MAX;
        if (stk_rd_reg[VAL_W-1] != tos_reg[VAL_W-1] && diff[VAL_W-1] != stk_rd_reg[VAL_W-1])
            diff = stk_rd_reg[VAL_W-1] ? Q_MIN : Q_MAX;
    end

    // A program that ends clean must leave exactly one entry.
    always_comb
    begin
        fin_status = status_reg;
        if (status_reg == ST_OK && cnt_reg != CNT_W'(1))
            fin_status = ST_MISMATCH;
        fin_ok = fin_status == ST_OK;
    end

    // Datapath next values, memory writes and unit starts.
    always_comb
    begin
        cnt_next        = cnt_reg;
        tos_next        = tos_reg;
        status_next     = status_reg;
        halted_next     = halted_reg;
        icnt_next       = icnt_reg;
        written_next    = written_reg;
        defined_next    = defined_reg;
        cbank_next      = cbank_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        stk_we          = 1'b0;
        stk_waddr       = cnt_m1[IDX_W-1:0];
        var_we          = 1'b0;
        var_waddr       = {~cbank_reg[sa], sa};
        mul_start       = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_EXEC:
            begin
                if (icnt_reg >= IC_W'(PROGRAM_MAX))
                begin
                    // The length limit outranks everything but an undefined slot.
                    if (status_reg != ST_UNDEF)
                        status_next = ST_LONG;
                end
                else
                begin
                    icnt_next = icnt_reg + 1'b1;
                    if (!halted_reg && status_reg != ST_UNDEF && status_reg != ST_LONG)
                    begin
                        if ((cmd_reg == CMD_LOAD || cmd_reg == CMD_STORE) &&
                            ({1'b0, slot_reg} >= (SLOT_W+1)'(SLOTS_USED) ||
                             (cmd_reg == CMD_LOAD && !defined_reg[sa] && !written_reg[sa])))
                        begin
                            status_next = ST_UNDEF;
                        end
                        else
                        begin
                            case (cmd_reg)
                                CMD_PUSH, CMD_LOAD:
                                begin
                                    if (status_reg == ST_OK)
                                    begin
                                        if (cnt_reg == CNT_W'(STACK_DEPTH))
                                            status_next = ST_OVERFLOW;
                                        else
                                        begin
                                            stk_we   = cnt_reg != '0;
                                            tos_next = (cmd_reg == CMD_PUSH) ? imm_reg
                                                                             : var_rd_reg;
                                            cnt_next = cnt_reg + 1'b1;
                                        end
                                    end
                                end
                                CMD_STORE:
                                begin
                                    // The mark is set even after a run-time error,
                                    // since later slot checks still read it.
                                    written_next[sa] = 1'b1;
                                    if (status_reg == ST_OK)
                                    begin
                                        if (cnt_reg == '0)
                                            status_next = ST_MISMATCH;
                                        else
                                            var_we = 1'b1;
                                    end
                                end
                                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                                begin
                                    if (status_reg == ST_OK)
                                    begin
                                        if (cnt_reg < CNT_W'(2))
                                            status_next = ST_MISMATCH;
                                        else if (cmd_reg == CMD_ADD)
                                        begin
                                            tos_next = sum;
                                            cnt_next = cnt_m1;
                                        end
                                        else if (cmd_reg == CMD_SUB)
                                        begin
                                            tos_next = diff;
                                            cnt_next = cnt_m1;
                                        end
                                        else if (cmd_reg == CMD_MUL)
                                            mul_start = 1'b1;
                                        else if (tos_reg == '0)
                                            status_next = ST_DIVZERO;
                                        else
                                            div_start = 1'b1;
                                    end
                                end
                                CMD_NEG:
                                begin
                                    if (status_reg == ST_OK)
                                    begin
                                        if (cnt_reg == '0)
                                            status_next = ST_MISMATCH;
                                        else
                                            tos_next = (tos_reg == Q_MIN) ? Q_MAX
                                                                          : (~tos_reg + 1'b1);
                                    end
                                end
                                CMD_HALT:
                                    halted_next = 1'b1;
                                default:
                                    ;
                            endcase
                        end
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    tos_next = mul_res;
                    cnt_next = cnt_m1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tos_next = div_res;
                    cnt_next = cnt_m1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_value_next  = fin_ok ? tos_reg : '0;
                    if (fin_ok)
                    begin
                        cbank_next   = cbank_reg ^ written_reg;
                        defined_next = defined_reg | written_reg;
                    end
                    cnt_next     = '0;
                    written_next = '0;
                    status_next  = ST_OK;
                    halted_next  = 1'b0;
                    icnt_next    = '0;
                end
            end
            default:
                ;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_EXEC;
            S_EXEC:
                if (mul_start)
                    state_next = S_MUL;
                else if (div_start)
                    state_next = S_DIV;
                else
                    state_next = last_reg ? S_FIN : S_IDLE;
            S_MUL:
                if (mul_done)
                    state_next = last_reg ? S_FIN : S_IDLE;
            S_DIV:
                if (div_done)
                    state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_tready = state_reg == S_IDLE;
        m_tvalid = out_valid_reg;
        m_tdata  = {{(OUT_DATA_W-STATUS_W-VAL_W){1'b0}}, out_value_reg, out_status_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            status_reg    <= ST_OK;
            halted_reg    <= 1'b0;
            icnt_reg      <= '0;
            written_reg   <= '0;
            defined_reg   <= '0;
            cbank_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            status_reg    <= status_next;
            halted_reg    <= halted_next;
            icnt_reg      <= icnt_next;
            written_reg   <= written_next;
            defined_reg   <= defined_next;
            cbank_reg     <= cbank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            imm_reg  <= in_imm;
            slot_reg <= in_slot;
            last_reg <= s_tlast;
        end
        tos_reg        <= tos_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Stack memory: the old top moves down on a push.
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= tos_reg;
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    // Variable memory: a store copies the top without popping it.
    always_ff @(posedge clk)
    begin
        if (var_we)
            var_mem[var_waddr] <= tos_reg;
        var_rd_reg <= var_mem[var_raddr];
    end

    // The stack never holds more than its depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A failed program reports a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> out_value_reg == '0)
        else $error("nonzero value with error status");

    // The divider is only started with a nonzero divisor and enough operands.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (tos_reg != '0 && cnt_reg >= CNT_W'(2)))
        else $error("divider started on bad operands");

    // Emitting a result resets the program state.
    a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=>
            (cnt_reg == '0 && written_reg == '0 && status_reg == ST_OK && icnt_reg == '0))
        else $error("program state not cleared after result");

endmodule

/* hw/rtl/fpsvm_mul.sv */
// ----------------------------------------------------------------------------
// fpsvm_mul
// Saturating Q32.32 multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module fpsvm_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fpsvm_pkg::VAL_W-1:0] a,
    input  logic [fpsvm_pkg::VAL_W-1:0] b,
    output logic                       done,
    output logic [fpsvm_pkg::VAL_W-1:0] result
);
    import fpsvm_pkg::*;

    localparam int HALF_W = VAL_W / 2;
    localparam int ACC_W  = 2 * VAL_W;

    logic              busy_reg;
    logic [2:0]        step_reg;
    logic [VAL_W-1:0]  x_reg;
    logic [VAL_W-1:0]  y_reg;
    logic              neg_reg;
    logic [VAL_W-1:0]  prod_reg;
    logic [1:0]        sel_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [HALF_W-1:0] xp;
    logic [HALF_W-1:0] yp;
    logic [ACC_W-1:0]  prod_sh;

    // Step k multiplies x half k[1] by y half k[0].
    always_comb
    begin
        xp = step_reg[1] ? x_reg[VAL_W-1:HALF_W] : x_reg[HALF_W-1:0];
        yp = step_reg[0] ? y_reg[VAL_W-1:HALF_W] : y_reg[HALF_W-1:0];
        case (sel_reg)
            2'd0:    prod_sh = {{VAL_W{1'b0}}, prod_reg};
            2'd3:    prod_sh = {prod_reg, {VAL_W{1'b0}}};
            default: prod_sh = {{HALF_W{1'b0}}, prod_reg, {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd5)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= q_mag(a);
            y_reg   <= q_mag(b);
            neg_reg <= a[VAL_W-1] ^ b[VAL_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < 3'd4)
            begin
                prod_reg <= xp * yp;
                sel_reg  <= step_reg[1:0];
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
                acc_reg <= acc_reg + prod_sh;
        end
    end

    assign done   = busy_reg && step_reg == 3'd5;
    assign result = q_signed({{HALF_W{1'b0}}, acc_reg[ACC_W-1:ACC_W-HALF_W]},
                             acc_reg[ACC_W-HALF_W-1:HALF_W], neg_reg);

endmodule

/* hw/rtl/fpsvm_div.sv */
// ----------------------------------------------------------------------------
// fpsvm_div
// Saturating Q32.32 divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpsvm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fpsvm_pkg::VAL_W-1:0] a,
    input  logic [fpsvm_pkg::VAL_W-1:0] b,
    output logic                       done,
    output logic [fpsvm_pkg::VAL_W-1:0] result
);
    import fpsvm_pkg::*;

    localparam int HALF_W = VAL_W / 2;
    localparam int NUM_W  = 2 * VAL_W;
    localparam int ITER_W = $clog2(NUM_W) + 1;

    logic              busy_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  d_reg;
    logic              neg_reg;
    logic [VAL_W:0]    trial;
    logic              fits;

    // The numerator shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        fits  = trial >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (iter_reg == ITER_W'(NUM_W))
                busy_reg <= 1'b0;
            else
                iter_reg <= iter_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {{HALF_W{1'b0}}, q_mag(a), {HALF_W{1'b0}}};
            d_reg   <= q_mag(b);
            rem_reg <= '0;
            neg_reg <= a[VAL_W-1] ^ b[VAL_W-1];
        end
        else if (busy_reg && iter_reg != ITER_W'(NUM_W))
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? VAL_W'(trial - {1'b0, d_reg}) : trial[VAL_W-1:0];
        end
    end

    assign done   = busy_reg && iter_reg == ITER_W'(NUM_W);
    assign result = q_signed(num_reg[NUM_W-1:VAL_W], num_reg[VAL_W-1:0], neg_reg);

endmodule

/* test/tb_fixed_point_stack_vm.sv */
// ----------------------------------------------------------------------------
// tb_fixed_point_stack_vm
// Self-checking bench for the Q32.32 stack machine. Programs are streamed in,
// one instruction per transaction. A scoreboard model of the stack, the
// variable slots and the status rules predicts each program result, and every
// result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_fixed_point_stack_vm;

    timeunit 1ns;
    timeprecision 1ps;

    import fpsvm_pkg::*;

    localparam int DEPTH    = DEF_STACK_DEPTH;
    localparam int SLOTS    = DEF_VAR_SLOTS;
    localparam int PROG_MAX = DEF_PROGRAM_MAX;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: cmd[3:0], immediate[67:4], slot[73:68], zero fill above.
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: status[2:0], value[66:3], zero fill above.
    logic [OUT_DATA_W-1:0] m_tdata;

    fixed_point_stack_vm DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    typedef struct packed {
        logic [3:0]       op;
        logic [VAL_W-1:0] imm;
        logic [5:0]       slot;
        logic             last;
    } instr_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] value;
    } outcome_t;

    // Directed table row. When has_exp is set the expected outcome typed in
    // the row must match what the scoreboard model predicts as well.
    typedef struct {
        instr_t   ins;
        bit       has_exp;
        outcome_t exp;
    } row_t;

    // Scoreboard copy of the machine state.
    logic [VAL_W-1:0] opnd[DEPTH];
    int               depth_cnt;
    logic [VAL_W-1:0] saved_vars[SLOTS];
    logic [VAL_W-1:0] scratch_vars[SLOTS];
    bit               scratch_used[SLOTS];
    bit               saved_valid[SLOTS];
    status_t          prog_status;
    bit               prog_halted;
    int               prog_len;

    outcome_t         pending_results[$];

    int  mismatches;
    int  results_seen;
    int  programs_sent;
    int  instr_sent;
    int  send_idle_pct;
    int  recv_idle_pct;

    // ------------------------------------------------------------------
    // Q32.32 arithmetic, saturating.
    // ------------------------------------------------------------------
    function automatic logic [63:0] mag64(logic [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic [63:0] sat_sign(logic [63:0] hi, logic [63:0] lo, bit neg);
        logic [63:0] lim;
        lim = neg ? Q_MIN : Q_MAX;
        if (hi != 0 || lo > lim)
            return lim;
        return neg ? -lo : lo;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> 63)
            return a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (((a ^ b) & (a ^ s)) >> 63)
            return a[63] ? Q_MIN : Q_MAX;
        return s;
    endfunction

    function automatic logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(mag64(a)) * 128'(mag64(b));
        // Drop 32 fraction bits; the rest splits into a high and low word.
        return sat_sign({32'd0, p[127:96]}, p[95:32], a[63] ^ b[63]);
    endfunction

    function automatic logic [63:0] sat_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] n;
        logic [127:0] q;
        n = {32'd0, mag64(a), 32'd0};
        q = n / 128'(mag64(b));
        return sat_sign(q[127:64], q[63:0], a[63] ^ b[63]);
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard model.
    // ------------------------------------------------------------------
    function automatic void clear_program();
        depth_cnt   = 0;
        prog_status = ST_OK;
        prog_halted = 0;
        prog_len    = 0;
        foreach (scratch_used[i])
            scratch_used[i] = 0;
    endfunction

    function automatic void flag_error(status_t code);
        if (prog_status == ST_OK)
            prog_status = code;
    endfunction

    function automatic void exec_instr(instr_t ins);
        bit          running;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        if (prog_status == ST_UNDEF || prog_status == ST_LONG)
            return;
        // Slot checks act like a compile step and outrank run-time errors.
        if (ins.op == CMD_LOAD || ins.op == CMD_STORE)
        begin
            if (ins.slot >= SLOTS ||
                (ins.op == CMD_LOAD && !saved_valid[ins.slot] && !scratch_used[ins.slot]))
            begin
                prog_status = ST_UNDEF;
                return;
            end
        end
        running = (prog_status == ST_OK);
        case (ins.op)
            CMD_PUSH, CMD_LOAD:
            begin
                if (!running)
                    return;
                if (depth_cnt >= DEPTH)
                begin
                    flag_error(ST_OVERFLOW);
                    return;
                end
                if (ins.op == CMD_PUSH)
                    opnd[depth_cnt] = ins.imm;
                else
                    opnd[depth_cnt] = scratch_used[ins.slot] ? scratch_vars[ins.slot]
                                                             : saved_vars[ins.slot];
                depth_cnt++;
            end
            CMD_STORE:
            begin
                // The written mark is set even after a run-time error.
                scratch_used[ins.slot] = 1;
                if (!running)
                    return;
                if (depth_cnt == 0)
                begin
                    flag_error(ST_MISMATCH);
                    return;
                end
                scratch_vars[ins.slot] = opnd[depth_cnt-1];
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (!running)
                    return;
                if (depth_cnt < 2)
                begin
                    flag_error(ST_MISMATCH);
                    return;
                end
                b = opnd[depth_cnt-1];
                a = opnd[depth_cnt-2];
                case (ins.op)
                    CMD_ADD: r = sat_add(a, b);
                    CMD_SUB: r = sat_sub(a, b);
                    CMD_MUL: r = sat_mul(a, b);
                    default:
                    begin
                        if (b == 0)
                        begin
                            flag_error(ST_DIVZERO);
                            return;
                        end
                        r = sat_div(a, b);
                    end
                endcase
                depth_cnt--;
                opnd[depth_cnt-1] = r;
            end
            CMD_NEG:
            begin
                if (!running)
                    return;
                if (depth_cnt == 0)
                begin
                    flag_error(ST_MISMATCH);
                    return;
                end
                a = opnd[depth_cnt-1];
                opnd[depth_cnt-1] = (a == Q_MIN) ? Q_MAX : -a;
            end
            CMD_HALT: prog_halted = 1;
            default: ;
        endcase
    endfunction

    // Advances the model by one instruction; returns 1 with the outcome on last.
    function automatic bit predict_vm(instr_t ins, output outcome_t res);
        res = '0;
        if (prog_len >= PROG_MAX)
        begin
            if (prog_status != ST_UNDEF)
                prog_status = ST_LONG;
        end
        else
        begin
            prog_len++;
            if (!prog_halted)
                exec_instr(ins);
        end
        if (!ins.last)
            return 0;
        res.status = prog_status;
        if (res.status == ST_OK && depth_cnt != 1)
            res.status = ST_MISMATCH;
        if (res.status == ST_OK)
        begin
            res.value = opnd[0];
            foreach (scratch_used[i])
                if (scratch_used[i])
                begin
                    saved_vars[i]  = scratch_vars[i];
                    saved_valid[i] = 1;
                end
        end
        clear_program();
        return 1;
    endfunction

    // ------------------------------------------------------------------
    // Clock and timeout.
    // ------------------------------------------------------------------
    initial clk = 0;
    always #6 clk = ~clk;

    initial
    begin
        #50ms;
        $display("fixed_point_stack_vm regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure and comparison against the oldest
    // expected outcome.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got.status = status_t'(m_tdata[2:0]);
            got.value  = m_tdata[66:3];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d value=%h",
                             got.status, got.value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.value !== want.value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result %0d: expected status=%0d value=%h, ",
                                  "got status=%0d value=%h"},
                                 results_seen, want.status, want.value,
                                 got.status, got.value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Sends one instruction and books its expected outcome at acceptance.
    // Valid stays high after acceptance; an idle cycle in a later call or the
    // end of stimulus takes it down, so it is driven once per time step.
    task automatic send_instr(instr_t ins);
        outcome_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ins.slot, ins.imm, ins.op};
        s_tlast  <= ins.last;
        do
            @(posedge clk);
        while (!s_tready);
        instr_sent++;
        if (predict_vm(ins, res))
        begin
            pending_results.push_back(res);
            programs_sent++;
        end
    endtask

    function automatic instr_t mk(cmd_t op, logic [63:0] imm = 0, logic [5:0] slot = 0,
                                  bit last = 0);
        instr_t i;
        i.op   = op;
        i.imm  = imm;
        i.slot = slot;
        i.last = last;
        return i;
    endfunction

    function automatic logic [63:0] rand_val();
        case ($urandom_range(5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 64'($signed($urandom_range(8) - 4)) <<< 32;
            3: return {{32{1'b0}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Random program: mostly well formed, keeping the stack depth in mind,
    // with a share of noise that triggers each error path.
    task automatic send_random_program();
        int     len;
        int     d;
        int     k;
        int     pick;
        instr_t ins;
        bit     noisy;
        noisy = ($urandom_range(99) < 20);
        len = ($urandom_range(49) == 0) ? $urandom_range(PROG_MAX + 8, 250)
                                        : $urandom_range(12, 1);
        d = 0;
        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(99);
            if (noisy && pick < 10)
                ins = mk(cmd_t'($urandom_range(15)), rand_val(), 6'($urandom()));
            else if (d < 2 && pick < 85 || pick < 25)
            begin
                if ($urandom_range(3) == 0)
                    ins = mk(CMD_LOAD, rand_val(), 6'($urandom_range(noisy ? 63 : 7)));
                else
                    ins = mk(CMD_PUSH, rand_val());
            end
            else if (pick < 35)
                ins = mk(CMD_STORE, rand_val(), 6'($urandom_range(7)));
            else if (pick < 40)
                ins = mk(CMD_NEG, rand_val());
            else if (pick < 44 && $urandom_range(3) == 0)
                ins = mk(CMD_DIV, rand_val());
            else if (pick < 97)
                ins = mk(cmd_t'($urandom_range(CMD_MUL, CMD_ADD)), rand_val());
            else
                ins = mk(CMD_HALT, rand_val());
            // Track a rough depth to steer toward legal programs.
            if (ins.op == CMD_PUSH || ins.op == CMD_LOAD)
                d++;
            else if (ins.op >= CMD_ADD && ins.op <= CMD_DIV && d > 0)
                d--;
            if (k == len - 1)
                ins.last = 1;
            send_instr(ins);
        end
    endtask

    initial
    begin
        row_t   dir[$];
        row_t   r;
        int     k;
        outcome_t res;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        programs_sent = 0;
        instr_sent    = 0;
        send_idle_pct = 8;
        recv_idle_pct = 70;
        foreach (saved_vars[i])
        begin
            saved_vars[i]   = '0;
            scratch_vars[i] = '0;
            saved_valid[i]  = 0;
        end
        clear_program();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: extremes, every opcode, error codes.
        dir.push_back('{mk(CMD_PUSH, Q_MAX, 0, 1), 1, '{ST_OK, Q_MAX}});
        dir.push_back('{mk(CMD_PUSH, Q_MIN), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_NEG, 0, 0, 1), 1, '{ST_OK, Q_MAX}});
        dir.push_back('{mk(CMD_LOAD, 0, 63, 1), 1, '{ST_UNDEF, 0}});
        dir.push_back('{mk(CMD_ADD, 0, 0, 1), 1, '{ST_MISMATCH, 0}});
        dir.push_back('{mk(CMD_PUSH, 64'h1_0000_0000), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_PUSH, 0), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_DIV, 0, 0, 1), 1, '{ST_DIVZERO, 0}});
        dir.push_back('{mk(CMD_PUSH, Q_MAX), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_PUSH, Q_MAX), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_ADD, 0, 0, 1), 1, '{ST_OK, Q_MAX}});
        dir.push_back('{mk(CMD_PUSH, Q_MIN), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_PUSH, Q_MAX), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_SUB, 0, 0, 1), 1, '{ST_OK, Q_MIN}});
        dir.push_back('{mk(CMD_PUSH, 64'h3_8000_0000), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_STORE, 0, 5), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_LOAD, 0, 5), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_MUL, 0, 0, 1), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_LOAD, 0, 5), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_PUSH, Q_MIN), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_DIV, 0, 0, 0), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_HALT, 0, 0, 0), 0, '{ST_OK, 0}});
        dir.push_back('{mk(cmd_t'(4'hF), ~64'd0, 6'h3F, 1), 0, '{ST_OK, 0}});
        dir.push_back('{mk(CMD_STORE, 0, 1, 1), 1, '{ST_MISMATCH, 0}});

        for (k = 0; k < dir.size(); k++)
        begin
            r = dir[k];
            if (r.has_exp && r.ins.last)
            begin
                // Cross-check the typed outcome against the model as the row is sent.
                pending_results.push_back(r.exp);
                send_instr(r.ins);
                res = pending_results.pop_back();
                if (res !== r.exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: table row %0d disagrees with the model", k);
                end
            end
            else
                send_instr(r.ins);
        end

        // Stack overflow: one program pushes past the stack depth.
        for (k = 0; k <= DEPTH; k++)
            send_instr(mk(CMD_PUSH, 64'(k), 0, k == DEPTH));

        // Random programs in three idling phases.
        for (k = 0; instr_sent < 1700; k++)
        begin
            if (instr_sent > 700 && send_idle_pct == 8)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 8;
            end
            else if (instr_sent > 1300 && send_idle_pct == 70)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_program();
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d instructions in %0d programs; %0d results checked.",
                 instr_sent, programs_sent, results_seen);
        $display("Covered saturating arithmetic, slot commit rules, all error codes.");
        if (mismatches == 0)
            $display("fixed_point_stack_vm regression: pass");
        else
            $display("fixed_point_stack_vm regression: fail");
        $finish;
    end

endmodule

/* fixed_point_stack_vm.f */
hw/rtl/fpsvm_pkg.sv
hw/rtl/fpsvm_mul.sv
hw/rtl/fpsvm_div.sv
hw/rtl/fixed_point_stack_vm.sv
test/tb_fixed_point_stack_vm.sv
